// ===== rtl/core/qsu_pkg.sv =====
// qsu_pkg: types, character codes and utf-8 constants for the quoted string decoder
// no dependencies; imported by quoted_string_unescape_utf8

package qsu_pkg;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_BODY  = 2'd1,
		PH_ESC   = 2'd2,
		PH_HEX   = 2'd3
	} phase_t;

	localparam logic [7:0] ChZero      = 8'h00;
	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChN         = 8'h6E;
	localparam logic [7:0] ChT         = 8'h74;
	localparam logic [7:0] ChR         = 8'h72;
	localparam logic [7:0] ChU         = 8'h75;
	localparam logic [7:0] ChNewline   = 8'h0A;
	localparam logic [7:0] ChTab       = 8'h09;
	localparam logic [7:0] ChCr        = 8'h0D;

	localparam logic [15:0] Utf8Max1 = 16'h007F;
	localparam logic [15:0] Utf8Max2 = 16'h07FF;
	localparam logic [7:0]  Utf8Lead2 = 8'hC0;
	localparam logic [7:0]  Utf8Lead3 = 8'hE0;
	localparam logic [7:0]  Utf8Cont  = 8'h80;
	localparam logic [7:0]  Utf8Mask6 = 8'h3F;

	// outcome of one byte handled as ordinary string text
	typedef struct packed {
		phase_t     ph;
		logic       emit;
		logic       done;
		logic       unterm;
	} body_res_t;

	function automatic body_res_t body_byte(input logic [7:0] b, input logic [7:0] quote);
		body_res_t r;
		r.ph     = PH_BODY;
		r.emit   = 1'b0;
		r.done   = 1'b0;
		r.unterm = 1'b0;
		if (b == ChZero) begin
			r.done   = 1'b1;
			r.unterm = 1'b1;
		end else if (b == ChBackslash) begin
			r.ph = PH_ESC;
		end else if (b == quote) begin
			r.done = 1'b1;
		end else begin
			r.emit = 1'b1;
		end
		return r;
	endfunction

	// value of a hex digit, valid flag in bit 4
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/quoted_string_unescape_utf8.sv =====
// quoted_string_unescape_utf8: byte-stream decoder for quoted string literals
// depends on qsu_pkg for phase codes, character constants and helpers

// Takes one source byte per transfer and decodes a quoted string literal: an
// optional opening quote is skipped, backslash escapes are resolved and \uXXXX
// becomes one to three utf-8 bytes. Each input byte is decoded in a single
// pass between the input register and a three-entry result buffer, so the
// block accepts one byte per cycle while the output is ready; a unicode escape
// that yields two or three bytes holds the input side while the result buffer
// drains one result per cycle with m_tready high. Bytes that produce no result
// (opening quote, backslash, leading hex digits) pass without any output
// transfer. The quote byte is written through the cfg channel, which is
// always ready and should be used only while idle. m_tuser carries has_byte,
// string_done and unterminated; m_tlast marks the last result caused by one
// input byte.

module quoted_string_unescape_utf8
	import qsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,   // quote_char
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // in_byte
	input  logic       s_tlast,    // end_of_source
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // out_byte
	output logic       m_tlast,    // last
	output logic [2:0] m_tuser     // has_byte, string_done, unterminated
);

	logic [7:0]  quote_q;
	phase_t      phase_q;
	logic [1:0]  hex_cnt_q;
	logic [11:0] hex_val_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;

	logic [7:0]  ob_byte_q [3];
	logic [1:0]  ob_cnt_q;
	logic        ob_has_q;
	logic        ob_done_q;
	logic        ob_unterm_q;

	logic        adv;

	// decode results
	phase_t      nx_phase;
	logic [1:0]  nx_hex_cnt;
	logic [11:0] nx_hex_val;
	logic [7:0]  d_byte [3];
	logic [1:0]  d_n;
	logic        d_done;
	logic        d_unterm;
	logic [1:0]  d_cnt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= 8'd34;
		end else if (cfg_valid) begin
			quote_q <= cfg_data;
		end
	end

	assign adv      = valid_s1 && (ob_cnt_q == 2'd0 || (ob_cnt_q == 2'd1 && m_tready));
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	always_comb begin
		body_res_t   br;
		logic [4:0]  hd;
		logic [15:0] cp;
		nx_phase   = phase_q;
		nx_hex_cnt = hex_cnt_q;
		nx_hex_val = hex_val_q;
		d_byte[0]  = 8'd0;
		d_byte[1]  = 8'd0;
		d_byte[2]  = 8'd0;
		d_n        = 2'd0;
		d_done     = 1'b0;
		d_unterm   = 1'b0;
		br         = body_byte(byte_s1, quote_q);
		hd         = hex_digit(byte_s1);
		cp         = {hex_val_q, hd[3:0]};
		unique case (phase_q)
			PH_START, PH_BODY: begin
				if (phase_q == PH_START && byte_s1 == quote_q) begin
					nx_phase = PH_BODY;
				end else begin
					nx_phase  = br.ph;
					d_done    = br.done;
					d_unterm  = br.unterm;
					d_byte[0] = br.emit ? byte_s1 : 8'd0;
					d_n       = {1'b0, br.emit};
				end
			end
			PH_ESC: begin
				if (byte_s1 == ChZero) begin
					d_done   = 1'b1;
					d_unterm = 1'b1;
				end else begin
					nx_phase = PH_BODY;
					d_n      = 2'd1;
					case (byte_s1)
						ChN:     d_byte[0] = ChNewline;
						ChT:     d_byte[0] = ChTab;
						ChR:     d_byte[0] = ChCr;
						ChU: begin
							nx_phase   = PH_HEX;
							nx_hex_cnt = 2'd0;
							nx_hex_val = 12'd0;
							d_n        = 2'd0;
						end
						default: d_byte[0] = byte_s1;
					endcase
				end
			end
			PH_HEX: begin
				if (!hd[4]) begin
					// short escape is dropped, byte taken as plain text
					nx_hex_cnt = 2'd0;
					nx_hex_val = 12'd0;
					nx_phase   = br.ph;
					d_done     = br.done;
					d_unterm   = br.unterm;
					d_byte[0]  = br.emit ? byte_s1 : 8'd0;
					d_n        = {1'b0, br.emit};
				end else if (hex_cnt_q != 2'd3) begin
					nx_hex_cnt = hex_cnt_q + 2'd1;
					nx_hex_val = cp[11:0];
				end else begin
					nx_phase   = PH_BODY;
					nx_hex_cnt = 2'd0;
					nx_hex_val = 12'd0;
					if (cp <= Utf8Max1) begin
						d_byte[0] = cp[7:0];
						d_n       = 2'd1;
					end else if (cp <= Utf8Max2) begin
						d_byte[0] = Utf8Lead2 | {3'd0, cp[10:6]};
						d_byte[1] = Utf8Cont | (cp[7:0] & Utf8Mask6);
						d_n       = 2'd2;
					end else begin
						d_byte[0] = Utf8Lead3 | {4'd0, cp[15:12]};
						d_byte[1] = Utf8Cont | (cp[13:6] & Utf8Mask6);
						d_byte[2] = Utf8Cont | (cp[7:0] & Utf8Mask6);
						d_n       = 2'd3;
					end
				end
			end
			default: nx_phase = PH_START;
		endcase
		if (!d_done && eos_s1) begin
			d_done   = 1'b1;
			d_unterm = 1'b1;
		end
		if (d_done) begin
			nx_phase   = PH_START;
			nx_hex_cnt = 2'd0;
			nx_hex_val = 12'd0;
		end
		// an ended string with no byte still gives one marker result
		d_cnt = (d_n == 2'd0) ? {1'b0, d_done} : d_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			hex_cnt_q <= 2'd0;
			hex_val_q <= 12'd0;
		end else if (adv) begin
			phase_q   <= nx_phase;
			hex_cnt_q <= nx_hex_cnt;
			hex_val_q <= nx_hex_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= 2'd0;
		end else if (adv) begin
			ob_cnt_q <= d_cnt;
		end else if (m_tvalid && m_tready) begin
			ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ob_byte_q[0] <= d_byte[0];
			ob_byte_q[1] <= d_byte[1];
			ob_byte_q[2] <= d_byte[2];
			ob_has_q     <= (d_n != 2'd0);
			ob_done_q    <= d_done;
			ob_unterm_q  <= d_unterm;
		end else if (m_tvalid && m_tready) begin
			ob_byte_q[0] <= ob_byte_q[1];
			ob_byte_q[1] <= ob_byte_q[2];
		end
	end

	assign m_tvalid = (ob_cnt_q != 2'd0);
	assign m_tdata  = ob_byte_q[0];
	assign m_tlast  = (ob_cnt_q == 2'd1);
	assign m_tuser  = {m_tlast && ob_done_q && ob_unterm_q, m_tlast && ob_done_q, ob_has_q};

	a_adv_drained: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (ob_cnt_q == 2'd0 || ob_cnt_q == 2'd1))
		else $error("result buffer overwritten before drained");

	a_done_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && d_done) |=> (phase_q == PH_START && hex_cnt_q == 2'd0))
		else $error("decoder not back at start after string end");

	a_hex_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(hex_cnt_q != 2'd0 || hex_val_q != 12'd0) |-> phase_q == PH_HEX)
		else $error("hex digits held outside unicode escape");

	a_marker_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tuser[1]))
		else $error("empty result that does not end a string");

endmodule
